### rtl/multichannel_wave_synth_mixer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wave synthesizer mixer
// Shared concurrent assertion forms, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_WAVE_SYNTH_MIXER_TOP_MACROS_SVH
`define MULTICHANNEL_WAVE_SYNTH_MIXER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MWSM_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mwsm assertion failed");
`define MWSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mwsm assertion failed");
`else
`define MWSM_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define MWSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/mwsm_pkg.sv
// ----------------------------------------------------------------------------
// Wave synthesizer mixer package
// Field widths, waveform codes, phase increment and sine tables.
// ----------------------------------------------------------------------------
package mwsm_pkg;

    localparam int NUM_CHANNELS    = 8;
    localparam int ROOT_OCTAVE     = 4;
    localparam int SAMPLE_RATE_HZ  = 8000;
    localparam int PHASE_FRAC_BITS = 24;
    localparam int SINE_TABLE_BITS = 10;

    localparam int IDX_W   = 20;
    localparam int CHAN_W  = 3;
    localparam int AMP_W   = 16;
    localparam int WAVE_W  = 16;
    localparam int SEL_W   = 3;
    localparam int SUM_W   = 20;
    localparam int MIX_W   = 16;
    localparam int PCM_W   = 8;
    localparam int Q15     = 15;
    localparam int PROD_W  = AMP_W + WAVE_W;
    localparam int SPROD_W = PROD_W - Q15;
    localparam int PH2_W   = PHASE_FRAC_BITS + 1;
    localparam int QB      = SINE_TABLE_BITS - 2;
    localparam int QTR     = 1 << QB;
    localparam int MIX_DIV = 2 * NUM_CHANNELS;
    localparam int MIX_MAX = (1 << (MIX_W - 1)) - 1;
    localparam int MIX_MIN = -(1 << (MIX_W - 1));

    localparam logic [SEL_W-1:0] WAVE_SINE   = 3'd0;
    localparam logic [SEL_W-1:0] WAVE_SQUARE = 3'd1;
    localparam logic [SEL_W-1:0] WAVE_SAW    = 3'd2;
    localparam logic [SEL_W-1:0] WAVE_RAMP   = 3'd3;
    localparam logic [SEL_W-1:0] WAVE_ORGAN  = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_sts;

    typedef logic [15:0] t_sine_tbl [0:QTR];
    typedef logic [PH2_W-1:0] t_step_tbl [0:NUM_CHANNELS-1];
    typedef longint unsigned t_semi_tbl [0:11];

    localparam t_semi_tbl SEMITONE_Q20 = '{
        64'd1048576, 64'd1110928, 64'd1176987, 64'd1246974, 64'd1321123, 64'd1399681,
        64'd1482911, 64'd1571089, 64'd1664511, 64'd1763488, 64'd1868350, 64'd1979448
    };

    function automatic t_sine_tbl build_sine();
        t_sine_tbl       tbl;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned r;
        longint unsigned y;
        for (int i = 0; i <= QTR; i++) begin
            x  = longint'(i) << (30 - QB);
            x2 = (x * x) >> 30;
            r  = 64'd172272;
            r  = 64'd5026996 - ((r * x2) >> 30);
            r  = 64'd85569306 - ((r * x2) >> 30);
            r  = 64'd693598668 - ((r * x2) >> 30);
            r  = 64'd1686629713 - ((r * x2) >> 30);
            y  = (x * r) >> 30;
            y  = (y + 64'd16384) >> 15;
            tbl[i] = (y > 64'd32767) ? 16'd32767 : y[15:0];
        end
        return tbl;
    endfunction

    function automatic t_step_tbl build_steps();
        t_step_tbl       tbl;
        longint unsigned num;
        longint unsigned stp;
        int              s;
        int              e;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            s   = ROOT_OCTAVE * 12 + c;
            e   = s / 12 + PHASE_FRAC_BITS;
            num = 64'd55 * SEMITONE_Q20[s % 12];
            if (e >= 21) begin
                num = num << (e - 21);
                stp = (num + longint'(SAMPLE_RATE_HZ / 2)) / SAMPLE_RATE_HZ;
            end else begin
                stp = (num + ((longint'(SAMPLE_RATE_HZ) << (21 - e)) >> 1))
                      / SAMPLE_RATE_HZ;
                stp = stp >> (21 - e);
            end
            tbl[c] = stp[PH2_W-1:0];
        end
        return tbl;
    endfunction

    localparam t_sine_tbl SINE_TBL = build_sine();
    localparam t_step_tbl STEP_TBL = build_steps();

endpackage

### rtl/mwsm_if.sv
// ----------------------------------------------------------------------------
// Wave synthesizer mixer channels
// Valid/ready interfaces for channel items and mixed samples.
// ----------------------------------------------------------------------------
interface mwsm_in_if import mwsm_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         sample_index;
    logic [CHAN_W-1:0]        channel;
    logic signed [AMP_W-1:0]  amplitude;

    modport source (output valid, sample_index, channel, amplitude, input ready);
    modport sink (input valid, sample_index, channel, amplitude, output ready);
endinterface

interface mwsm_out_if import mwsm_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [PCM_W-1:0]         pcm_byte;
    logic signed [MIX_W-1:0]  mixed_sample;
    logic [IDX_W-1:0]         out_index;

    modport source (output valid, pcm_byte, mixed_sample, out_index, input ready);
    modport sink (input valid, pcm_byte, mixed_sample, out_index, output ready);
endinterface

### rtl/mwsm_phase_mul.sv
// ----------------------------------------------------------------------------
// Phase multiplier
// Bit-serial sample index times phase increment, modulo two turns.
// ----------------------------------------------------------------------------
module mwsm_phase_mul import mwsm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [IDX_W-1:0] i_mplier,
    input  logic [PH2_W-1:0] i_mcand,
    output t_mul_sts         o_sts,
    output logic [PH2_W-1:0] o_prod
);

    localparam int CNT_W = $clog2(IDX_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_mplier;
    logic [PH2_W-1:0] r_mcand;
    logic [PH2_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(IDX_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt    <= '0;
            r_mplier <= i_mplier;
            r_mcand  <= i_mcand;
            r_acc    <= '0;
        end else if (r_busy) begin
            r_cnt    <= r_cnt + CNT_W'(1);
            r_mplier <= r_mplier >> 1;
            r_mcand  <= r_mcand << 1;
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc;

endmodule

### rtl/mwsm_wave.sv
// ----------------------------------------------------------------------------
// Waveform generator
// Sine, square, saw, ramp and organ value at a phase, registered.
// ----------------------------------------------------------------------------
module mwsm_wave import mwsm_pkg::*; (
    input  logic                     i_clk,
    input  logic [PH2_W-1:0]         i_p2,
    input  logic [SEL_W-1:0]         i_sel,
    output logic signed [WAVE_W-1:0] o_wave
);

    function automatic logic signed [WAVE_W-1:0] sine_at(
        input logic [SINE_TABLE_BITS-1:0] k
    );
        logic [1:0]    quad;
        logic [QB-1:0] off;
        logic [QB:0]   pos;
        logic [15:0]   mag;
        quad = k[SINE_TABLE_BITS-1 -: 2];
        off  = k[QB-1:0];
        pos  = quad[0] ? ((QB + 1)'(QTR) - {1'b0, off}) : {1'b0, off};
        mag  = SINE_TBL[pos];
        return quad[1] ? -$signed(mag) : $signed(mag);
    endfunction

    logic [PHASE_FRAC_BITS-1:0] u;
    logic [PH2_W-1:0]           p3_full;
    logic [15:0]                uq;
    logic signed [16:0]         saw_hi;
    logic signed [16:0]         saw_lo;
    logic signed [16:0]         organ_sum;
    logic signed [WAVE_W-1:0]   n_wave;
    logic signed [WAVE_W-1:0]   r_wave;

    assign u       = i_p2[PHASE_FRAC_BITS-1:0];
    assign p3_full = i_p2 + (i_p2 >> 1);
    assign uq      = u[PHASE_FRAC_BITS-1 -: 16];
    assign saw_hi  = 17'sd32768 - $signed({1'b0, uq[14:0], 1'b0});
    assign saw_lo  = $signed({1'b0, uq[14:0], 1'b0}) - 17'sd32768;

    always_comb begin
        organ_sum = 17'(sine_at(u[PHASE_FRAC_BITS-1 -: SINE_TABLE_BITS]))
                  + 17'(sine_at(p3_full[PHASE_FRAC_BITS-1 -: SINE_TABLE_BITS]));
        case (i_sel)
            WAVE_SINE: begin
                n_wave = sine_at(u[PHASE_FRAC_BITS-1 -: SINE_TABLE_BITS]);
            end
            WAVE_SQUARE: begin
                n_wave = (uq > 16'h8000) ? 16'sd32767 : -16'sd32768;
            end
            WAVE_SAW: begin
                if (uq > 16'h8000) begin
                    n_wave = (saw_hi > 17'sd32767) ? 16'sd32767 : saw_hi[15:0];
                end else begin
                    n_wave = saw_lo[15:0];
                end
            end
            WAVE_RAMP: begin
                n_wave = $signed({~uq[15], uq[14:0]});
            end
            WAVE_ORGAN: begin
                n_wave = organ_sum[16:1];
            end
            default: begin
                n_wave = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_wave <= n_wave;
    end

    assign o_wave = r_wave;

endmodule

### rtl/mwsm_amp_mul.sv
// ----------------------------------------------------------------------------
// Amplitude multiplier
// Bit-serial signed product of amplitude and waveform value.
// ----------------------------------------------------------------------------
module mwsm_amp_mul import mwsm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [AMP_W-1:0]  i_mplier,
    input  logic signed [WAVE_W-1:0] i_mcand,
    output t_mul_sts                 o_sts,
    output logic signed [PROD_W-1:0] o_prod
);

    localparam int CNT_W = $clog2(AMP_W);

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_W-1:0]         r_cnt;
    logic [AMP_W-1:0]         r_mplier;
    logic signed [PROD_W-1:0] r_mcand;
    logic signed [PROD_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(AMP_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // The top multiplier bit carries negative weight.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt    <= '0;
            r_mplier <= i_mplier;
            r_mcand  <= PROD_W'(i_mcand);
            r_acc    <= '0;
        end else if (r_busy) begin
            r_cnt    <= r_cnt + CNT_W'(1);
            r_mplier <= r_mplier >> 1;
            r_mcand  <= r_mcand <<< 1;
            if (r_mplier[0]) begin
                if (r_cnt == CNT_W'(AMP_W - 1)) begin
                    r_acc <= r_acc - r_mcand;
                end else begin
                    r_acc <= r_acc + r_mcand;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc;

endmodule

### rtl/multichannel_wave_synth_mixer_top.sv
// ----------------------------------------------------------------------------
// Multichannel wave synthesizer mixer
// Each channel item passes the phase, wave, amplitude and accumulate states in turn.
// A new item is taken only back in the idle state, as the serial phase multiplier
// and the serial amplitude multiplier run one after the other.
// Reset clears the channel sum, the sequencer and the output valid, and selects
// the organ waveform.
// ----------------------------------------------------------------------------
`include "multichannel_wave_synth_mixer_top_macros.svh"

module multichannel_wave_synth_mixer_top import mwsm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [SEL_W-1:0] i_cfg_wdata,
    mwsm_in_if.sink          i_in,
    mwsm_out_if.source       o_out
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PHASE = 5'b00010,
        S_WAVE  = 5'b00100,
        S_AMP   = 5'b01000,
        S_ACC   = 5'b10000
    } t_state;

    localparam logic signed [SUM_W:0] SUM_HI = (SUM_W + 1)'((1 << (SUM_W - 1)) - 1);
    localparam logic signed [SUM_W:0] SUM_LO = (SUM_W + 1)'(-(1 << (SUM_W - 1)));

    t_state                    r_state;
    t_state                    n_state;
    logic [SEL_W-1:0]          r_sel;
    logic [IDX_W-1:0]          r_idx;
    logic [CHAN_W-1:0]         r_chan;
    logic signed [AMP_W-1:0]   r_amp;
    logic signed [SUM_W-1:0]   r_sum;
    logic                      r_out_valid;
    logic [PCM_W-1:0]          r_pcm;
    logic signed [MIX_W-1:0]   r_mix;
    logic [IDX_W-1:0]          r_out_idx;

    logic                      in_xfer;
    logic                      chan_ok;
    logic                      closing;
    logic                      phase_start;
    logic                      amp_start;
    logic                      sum_we;
    logic                      out_load;
    t_mul_sts                  phase_sts;
    t_mul_sts                  amp_sts;
    logic [PH2_W-1:0]          p2;
    logic signed [WAVE_W-1:0]  wave;
    logic signed [PROD_W-1:0]  amp_prod;
    logic signed [SPROD_W-1:0] prod;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    int                        mix_int;
    logic signed [MIX_W-1:0]   mix;
    logic [MIX_W-1:0]          mix_off;
    logic [MIX_W+PCM_W-1:0]    pcm_prod;

    assign in_xfer = i_in.valid && i_in.ready;
    assign chan_ok = int'(i_in.channel) < NUM_CHANNELS;
    assign closing = (r_chan == CHAN_W'(NUM_CHANNELS - 1));

    mwsm_phase_mul u_phase_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (phase_start),
        .i_mplier (i_in.sample_index),
        .i_mcand  (STEP_TBL[i_in.channel]),
        .o_sts    (phase_sts),
        .o_prod   (p2)
    );

    mwsm_wave u_wave (
        .i_clk  (i_clk),
        .i_p2   (p2),
        .i_sel  (r_sel),
        .o_wave (wave)
    );

    mwsm_amp_mul u_amp_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (amp_start),
        .i_mplier (r_amp),
        .i_mcand  (wave),
        .o_sts    (amp_sts),
        .o_prod   (amp_prod)
    );

    always_comb begin
        prod     = amp_prod[PROD_W-1:Q15];
        sum_wide = (SUM_W + 1)'(r_sum) + (SUM_W + 1)'(prod);
        if (sum_wide > SUM_HI) begin
            sum_sat = SUM_HI[SUM_W-1:0];
        end else if (sum_wide < SUM_LO) begin
            sum_sat = SUM_LO[SUM_W-1:0];
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
        mix_int = int'(sum_sat) / MIX_DIV;
        if (mix_int > MIX_MAX) begin
            mix = MIX_W'(MIX_MAX);
        end else if (mix_int < MIX_MIN) begin
            mix = MIX_W'(MIX_MIN);
        end else begin
            mix = MIX_W'(mix_int);
        end
        mix_off  = {~mix[MIX_W-1], mix[MIX_W-2:0]};
        pcm_prod = {mix_off, PCM_W'(0)} - (MIX_W + PCM_W)'(mix_off);
    end

    always_comb begin
        n_state     = r_state;
        phase_start = 1'b0;
        amp_start   = 1'b0;
        sum_we      = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && chan_ok) begin
                    phase_start = 1'b1;
                    n_state     = S_PHASE;
                end
            end
            S_PHASE: begin
                if (phase_sts.done) begin
                    n_state = S_WAVE;
                end
            end
            S_WAVE: begin
                amp_start = 1'b1;
                n_state   = S_AMP;
            end
            S_AMP: begin
                if (amp_sts.done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (!closing) begin
                    sum_we  = 1'b1;
                    n_state = S_IDLE;
                end else if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= WAVE_ORGAN;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_sel <= i_cfg_wdata;
            end
            if (sum_we) begin
                r_sum <= sum_sat;
            end else if (out_load) begin
                r_sum <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_idx  <= i_in.sample_index;
            r_chan <= i_in.channel;
            r_amp  <= i_in.amplitude;
        end
        if (out_load) begin
            r_pcm     <= pcm_prod[MIX_W+PCM_W-1:MIX_W];
            r_mix     <= mix;
            r_out_idx <= r_idx;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.pcm_byte     = r_pcm;
    assign o_out.mixed_sample = r_mix;
    assign o_out.out_index    = r_out_idx;

    `MWSM_ASSERT_IMPLIES(a_phase_done_in_phase, i_clk, i_rst_n, phase_sts.done, r_state == S_PHASE)
    `MWSM_ASSERT_IMPLIES(a_amp_done_in_amp, i_clk, i_rst_n, amp_sts.done, r_state == S_AMP)
    `MWSM_ASSERT_IMPLIES(a_mul_exclusive, i_clk, i_rst_n, phase_sts.busy, !amp_sts.busy)
    `MWSM_ASSERT_NEXT(a_close_clears_sum, i_clk, i_rst_n, out_load, r_out_valid && (r_sum == '0))

endmodule
